// ===== rtl/ccb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants for the c comment blanker: character codes, scan mode codes
// and output queue sizing; no dependencies

package ccb_pkg;

    localparam int BYTE_W = 8;

    // character codes
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

    // scan mode codes
    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_NORMAL    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SLASH     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LIT       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LIT_ESC   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LINE      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BLOCK     = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BLOCK_STR = 3'd6;

    // result queue: room for two results of one byte plus slack for a stalled sink
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int PUSH_W  = 2;
    localparam int MAX_RES = 2;

endpackage

// ===== rtl/c_comment_blanker_core.sv =====
`timescale 1ns / 1ps
// c comment blanker top level: replaces c line and block comments by spaces
// in a byte stream, keeping newlines and quoted literals; uses ccb_pkg
//
// channel   dir  tdata          tlast            notes
// s_axis    in   [7:0] in_byte  in_last          one source byte per transfer
// m_axis    out  [7:0] out_byte out_last         zero, one or two per input byte
//
// one input byte per cycle while s_axis_tready is high; scan mode update and
// result selection are one level of logic from the port into a four-entry result queue.
// first result is registered into the queue and can appear in the cycle after its input transfer.
// s_axis_tready drops while the queue holds more than two results.
// aresetn (synchronous, active low) clears scan mode, quote kind and the queue.

module c_comment_blanker_core
    import ccb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic              m_axis_tlast
);

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              quote_single_reg, quote_single_next;

    logic [BYTE_W-1:0] q_byte_reg [QDEPTH];
    logic              q_last_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic              s_fire, m_fire;
    logic [BYTE_W-1:0] in_b;
    logic [BYTE_W-1:0] quote_ch;

    // normal text handling of the current byte
    logic [MODE_W-1:0] plain_mode;
    logic              plain_quote;
    logic              plain_emit;

    logic [BYTE_W-1:0] res0_byte, res1_byte;
    logic [PUSH_W-1:0] n_res;
    logic [PUSH_W-1:0] n_push;
    logic              last0, last1;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign in_b   = s_axis_tdata;
    assign quote_ch = quote_single_reg ? CH_SQUOTE : CH_DQUOTE;

    assign s_axis_tready = (count_reg <= QCNT_W'(QDEPTH - MAX_RES));
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = q_byte_reg[rd_ptr_reg];
    assign m_axis_tlast  = q_last_reg[rd_ptr_reg];

    always_comb begin
        plain_mode  = MODE_NORMAL;
        plain_quote = quote_single_reg;
        plain_emit  = 1'b1;
        if (in_b == CH_DQUOTE || in_b == CH_SQUOTE) begin
            plain_mode  = MODE_LIT;
            plain_quote = (in_b == CH_SQUOTE);
        end else if (in_b == CH_SLASH && !s_axis_tlast) begin
            plain_mode = MODE_SLASH;
            plain_emit = 1'b0;
        end
    end

    always_comb begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        res0_byte         = in_b;
        res1_byte         = in_b;
        n_res             = PUSH_W'(1);
        unique case (mode_reg)
            MODE_SLASH: begin
                if (in_b == CH_SLASH || in_b == CH_STAR) begin
                    res0_byte = CH_SPACE;
                    res1_byte = CH_SPACE;
                    n_res     = PUSH_W'(2);
                    mode_next = (in_b == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                end else begin
                    // held slash goes out first, then the byte as normal text
                    res0_byte         = CH_SLASH;
                    res1_byte         = in_b;
                    n_res             = plain_emit ? PUSH_W'(2) : PUSH_W'(1);
                    mode_next         = plain_mode;
                    quote_single_next = plain_quote;
                end
            end
            MODE_LIT: begin
                if (in_b == quote_ch) begin
                    mode_next = MODE_NORMAL;
                end else if (in_b == CH_BSLASH) begin
                    mode_next = MODE_LIT_ESC;
                end
            end
            MODE_LIT_ESC: begin
                mode_next = MODE_LIT;
            end
            MODE_LINE: begin
                if (in_b == CH_NL) begin
                    mode_next = MODE_NORMAL;
                end else begin
                    res0_byte = CH_SPACE;
                end
            end
            MODE_BLOCK, MODE_BLOCK_STR: begin
                if (in_b == CH_SLASH && mode_reg == MODE_BLOCK_STR) begin
                    mode_next = MODE_NORMAL;
                    res0_byte = CH_SPACE;
                end else if (in_b == CH_STAR) begin
                    mode_next = MODE_BLOCK_STR;
                    res0_byte = CH_SPACE;
                end else begin
                    mode_next = MODE_BLOCK;
                    res0_byte = (in_b == CH_NL) ? CH_NL : CH_SPACE;
                end
            end
            default: begin
                // normal text, also the unused code
                mode_next         = plain_mode;
                quote_single_next = plain_quote;
                n_res             = plain_emit ? PUSH_W'(1) : PUSH_W'(0);
            end
        endcase
        // end of text: mark the final result and start over
        if (s_axis_tlast) begin
            mode_next         = MODE_NORMAL;
            quote_single_next = 1'b0;
        end
    end

    assign last0  = s_axis_tlast && (n_res == PUSH_W'(1));
    assign last1  = s_axis_tlast;
    assign n_push = s_fire ? n_res : '0;

    assign count_next = count_reg + QCNT_W'(n_push) - QCNT_W'(m_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_NORMAL;
            quote_single_reg <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end else begin
            if (s_fire) begin
                mode_reg         <= mode_next;
                quote_single_reg <= quote_single_next;
            end
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(n_push);
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (n_push != '0) begin
            q_byte_reg[wr_ptr_reg] <= res0_byte;
            q_last_reg[wr_ptr_reg] <= last0;
        end
        if (n_push == PUSH_W'(2)) begin
            q_byte_reg[wr_ptr_reg + QPTR_W'(1)] <= res1_byte;
            q_last_reg[wr_ptr_reg + QPTR_W'(1)] <= last1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue count out of range");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> count_reg == $past(count_reg) + QCNT_W'($past(n_push))
                             - QCNT_W'($past(m_fire)))
        else $error("result queue count lost track of transfers");

    a_last_resets_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_axis_tlast |=> mode_reg == MODE_NORMAL && !quote_single_reg)
        else $error("scan state not cleared after final byte");

    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_axis_tlast |-> n_res != '0)
        else $error("final byte produced no result");
`endif

endmodule
